FILE: src/ula_pkg.sv
// ----------------------------------------------------------------------------
// ula_pkg
// Shared codes, widths and the pipeline advance struct for the uniaxial
// Legendre anisotropy evaluator.
// ----------------------------------------------------------------------------
package ula_pkg;

	localparam int KIND_WIDTH = 2;
	localparam int OUT_WIDTH  = 38;

	// request kinds; the fourth code is reserved and yields zero
	localparam logic [KIND_WIDTH-1:0] KIND_ENERGY = 2'd0;
	localparam logic [KIND_WIDTH-1:0] KIND_DIFF   = 2'd1;
	localparam logic [KIND_WIDTH-1:0] KIND_FIELD  = 2'd2;

	// per-stage load enables, one bit for each pipeline register stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} ula_adv_t;

endpackage

FILE: src/uniaxial_legendre_anisotropy.sv
// ----------------------------------------------------------------------------
// uniaxial_legendre_anisotropy
// Legendre order 2/4/6 uniaxial anisotropy energy, energy difference and
// z field for one spin per request.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel in_valid/in_stall carries kind, spin_z, spin_z_final and
//    the three coefficients; a request is taken when in_valid is high and
//    in_stall is low
//  - output channel out_valid/out_stall carries result_value (Q16.16,
//    saturated to 38 bits); the reserved kind gives zero
//  - seven register stages: squares, higher powers (two), polynomials,
//    coefficient products, sums, combine/saturate into the output register
//  - out_valid rises once a request is loaded into the output register of the
//    last stage, and the result can then be taken when nothing stalls
//  - throughput is one request per cycle while out_stall stays low; the two z
//    values run in two parallel lanes so difference mode needs no extra pass
//  - when out_stall is high, bubbles in the pipe still close up; in_stall
//    rises only once every stage holds a request
//  - the result register holds steady while stalled
//  - arst_n empties the pipeline at once; no requests are lost to a stall
// ----------------------------------------------------------------------------
module uniaxial_legendre_anisotropy #(
	parameter int SPIN_FRAC_BITS = 15,
	parameter int COEFF_WIDTH    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ula_pkg::KIND_WIDTH-1:0]       kind,
	input  logic signed [SPIN_FRAC_BITS:0]       spin_z,
	input  logic signed [SPIN_FRAC_BITS:0]       spin_z_final,
	input  logic signed [COEFF_WIDTH-1:0]        k2_coeff,
	input  logic signed [COEFF_WIDTH-1:0]        k4_coeff,
	input  logic signed [COEFF_WIDTH-1:0]        k6_coeff,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ula_pkg::OUT_WIDTH-1:0] result_value
);
	import ula_pkg::*;

	localparam int F  = SPIN_FRAC_BITS;
	localparam int CW = COEFF_WIDTH;
	localparam int PW = F + 10;
	localparam int SW = CW + 12;
	localparam int DW = ((SW > OUT_WIDTH) ? SW : OUT_WIDTH) + 1;

	localparam logic signed [DW-1:0] OUT_MAX =
		{{(DW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
	localparam logic signed [DW-1:0] OUT_MIN =
		{{(DW-OUT_WIDTH+1){1'b1}}, {(OUT_WIDTH-1){1'b0}}};

	ula_adv_t adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [KIND_WIDTH-1:0] kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic signed [CW-1:0] k2_s1, k2_s2, k2_s3, k2_s4;
	logic signed [CW-1:0] k4_s1, k4_s2, k4_s3, k4_s4;
	logic signed [CW-1:0] k6_s1, k6_s2, k6_s3, k6_s4;

	logic signed [PW-1:0] pa2_s4, pa4_s4, pa6_s4;
	logic signed [PW-1:0] pb2_s4, pb4_s4, pb6_s4;
	logic signed [SW-1:0] suma_s6, sumb_s6;

	logic signed [DW-1:0]        total;
	logic signed [OUT_WIDTH-1:0] res_next;
	logic signed [OUT_WIDTH-1:0] result_s7;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		adv.s7 = !vld_s7 || !out_stall;
		adv.s6 = !vld_s6 || adv.s7;
		adv.s5 = !vld_s5 || adv.s6;
		adv.s4 = !vld_s4 || adv.s5;
		adv.s3 = !vld_s3 || adv.s4;
		adv.s2 = !vld_s2 || adv.s3;
		adv.s1 = !vld_s1 || adv.s2;
	end

	assign in_stall = !adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv.s1) vld_s1 <= in_valid;
			if (adv.s2) vld_s2 <= vld_s1;
			if (adv.s3) vld_s3 <= vld_s2;
			if (adv.s4) vld_s4 <= vld_s3;
			if (adv.s5) vld_s5 <= vld_s4;
			if (adv.s6) vld_s6 <= vld_s5;
			if (adv.s7) vld_s7 <= vld_s6;
		end
	end

	// kind and coefficients ride alongside the lanes
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			kind_s1 <= kind;
			k2_s1   <= k2_coeff;
			k4_s1   <= k4_coeff;
			k6_s1   <= k6_coeff;
		end
		if (adv.s2) begin
			kind_s2 <= kind_s1;
			k2_s2   <= k2_s1;
			k4_s2   <= k4_s1;
			k6_s2   <= k6_s1;
		end
		if (adv.s3) begin
			kind_s3 <= kind_s2;
			k2_s3   <= k2_s2;
			k4_s3   <= k4_s2;
			k6_s3   <= k6_s2;
		end
		if (adv.s4) begin
			kind_s4 <= kind_s3;
			k2_s4   <= k2_s3;
			k4_s4   <= k4_s3;
			k6_s4   <= k6_s3;
		end
		if (adv.s5) kind_s5 <= kind_s4;
		if (adv.s6) kind_s6 <= kind_s5;
	end

	// lane a: spin_z (energy, field, or initial z); lane b: final z
	ula_lane #(
		.SPIN_FRAC_BITS(F)
	) u_lane_a (
		.clk   (clk),
		.adv   (adv),
		.z     (spin_z),
		.field (kind_s3 == KIND_FIELD),
		.p2_s4 (pa2_s4),
		.p4_s4 (pa4_s4),
		.p6_s4 (pa6_s4)
	);

	ula_lane #(
		.SPIN_FRAC_BITS(F)
	) u_lane_b (
		.clk   (clk),
		.adv   (adv),
		.z     (spin_z_final),
		.field (1'b0),
		.p2_s4 (pb2_s4),
		.p4_s4 (pb4_s4),
		.p6_s4 (pb6_s4)
	);

	ula_terms #(
		.SPIN_FRAC_BITS(F),
		.COEFF_WIDTH   (CW)
	) u_terms_a (
		.clk    (clk),
		.adv    (adv),
		.k2     (k2_s4),
		.k4     (k4_s4),
		.k6     (k6_s4),
		.p2     (pa2_s4),
		.p4     (pa4_s4),
		.p6     (pa6_s4),
		.sum_s6 (suma_s6)
	);

	ula_terms #(
		.SPIN_FRAC_BITS(F),
		.COEFF_WIDTH   (CW)
	) u_terms_b (
		.clk    (clk),
		.adv    (adv),
		.k2     (k2_s4),
		.k4     (k4_s4),
		.k6     (k6_s4),
		.p2     (pb2_s4),
		.p4     (pb4_s4),
		.p6     (pb6_s4),
		.sum_s6 (sumb_s6)
	);

	// stage 7: pick or subtract, then clamp to the output range
	always_comb begin
		unique case (kind_s6)
			KIND_ENERGY, KIND_FIELD: total = DW'(suma_s6);
			KIND_DIFF:               total = DW'(sumb_s6) - DW'(suma_s6);
			default:                 total = '0;
		endcase

		if (total > OUT_MAX) begin
			res_next = OUT_MAX[OUT_WIDTH-1:0];
		end else if (total < OUT_MIN) begin
			res_next = OUT_MIN[OUT_WIDTH-1:0];
		end else begin
			res_next = total[OUT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s7) result_s7 <= res_next;
	end

	assign out_valid    = vld_s7;
	assign result_value = result_s7;

endmodule

FILE: src/ula_lane.sv
// ----------------------------------------------------------------------------
// ula_lane
// Powers of z over three stages, then the order 2, 4 and 6 Legendre
// polynomials (or negated derivatives in field mode) in a fourth stage.
// ----------------------------------------------------------------------------
module ula_lane #(
	parameter int SPIN_FRAC_BITS = 15
) (
	input  logic                       clk,
	input  ula_pkg::ula_adv_t          adv,
	input  logic signed [SPIN_FRAC_BITS:0]    z,
	input  logic                       field,
	output logic signed [SPIN_FRAC_BITS+9:0]  p2_s4,
	output logic signed [SPIN_FRAC_BITS+9:0]  p4_s4,
	output logic signed [SPIN_FRAC_BITS+9:0]  p6_s4
);
	import ula_pkg::*;

	localparam int F  = SPIN_FRAC_BITS;
	localparam int ZW = F + 1;
	localparam int UW = F + 2;
	localparam int NW = F + 12;
	localparam int PW = F + 10;

	localparam logic signed [NW-1:0] ONE  = NW'(1) <<< F;
	localparam logic signed [NW-1:0] C3   = NW'(3);
	localparam logic signed [NW-1:0] C5   = NW'(5);
	localparam logic signed [NW-1:0] C15  = NW'(15);
	localparam logic signed [NW-1:0] C30  = NW'(30);
	localparam logic signed [NW-1:0] C35  = NW'(35);
	localparam logic signed [NW-1:0] C105 = NW'(105);
	localparam logic signed [NW-1:0] C231 = NW'(231);
	localparam logic signed [NW-1:0] C315 = NW'(315);
	localparam logic signed [NW-1:0] C630 = NW'(630);
	localparam logic signed [NW-1:0] C693 = NW'(693);

	logic signed [2*ZW-1:0]   zz;
	logic signed [2*UW-1:0]   uu1, uu2;
	logic signed [ZW+UW-1:0]  zu1, zu2;

	logic signed [ZW-1:0] z_s1, z_s2, z_s3, z3_s2, z3_s3, z5_s3;
	logic signed [UW-1:0] u_s1, u_s2, u_s3, u2_s2, u2_s3, u3_s3;

	logic signed [NW-1:0] ze, z3e, z5e, ue, u2e, u3e;
	logic signed [NW-1:0] p2n, p4n, p6n, d2n, d4n, d6n;
	logic signed [NW-1:0] p2w, p4w, p6w, d4w, d6w;
	logic signed [PW-1:0] p2c, p4c, p6c, d2c, d4c, d6c;

	// stage 1: u = z^2
	assign zz = z * z;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			z_s1 <= z;
			u_s1 <= zz[F+UW-1:F];
		end
	end

	// stage 2: u^2 and z^3
	assign uu1 = u_s1 * u_s1;
	assign zu1 = z_s1 * u_s1;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			z_s2  <= z_s1;
			u_s2  <= u_s1;
			u2_s2 <= uu1[F+UW-1:F];
			z3_s2 <= zu1[F+ZW-1:F];
		end
	end

	// stage 3: u^3 and z^5
	assign uu2 = u2_s2 * u_s2;
	assign zu2 = z3_s2 * u_s2;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			z_s3  <= z_s2;
			z3_s3 <= z3_s2;
			z5_s3 <= zu2[F+ZW-1:F];
			u_s3  <= u_s2;
			u2_s3 <= u2_s2;
			u3_s3 <= uu2[F+UW-1:F];
		end
	end

	// stage 4: polynomial sums, constant multiplies only
	always_comb begin
		ze  = NW'(z_s3);
		z3e = NW'(z3_s3);
		z5e = NW'(z5_s3);
		ue  = NW'(u_s3);
		u2e = NW'(u2_s3);
		u3e = NW'(u3_s3);

		p2n = C3 * ue - ONE;
		p4n = C35 * u2e - C30 * ue + C3 * ONE;
		p6n = C231 * u3e - C315 * u2e + C105 * ue - C5 * ONE;
		d2n = C3 * ze;
		d4n = C35 * z3e - C15 * ze;
		d6n = C693 * z5e - C630 * z3e + C105 * ze;

		p2w = p2n >>> 1;
		p4w = p4n >>> 3;
		p6w = p6n >>> 4;
		d4w = d4n >>> 1;
		d6w = d6n >>> 3;

		p2c = p2w[PW-1:0];
		p4c = p4w[PW-1:0];
		p6c = p6w[PW-1:0];
		d2c = d2n[PW-1:0];
		d4c = d4w[PW-1:0];
		d6c = d6w[PW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			if (field) begin
				p2_s4 <= -d2c;
				p4_s4 <= -d4c;
				p6_s4 <= -d6c;
			end else begin
				p2_s4 <= p2c;
				p4_s4 <= p4c;
				p6_s4 <= p6c;
			end
		end
	end

endmodule

FILE: src/ula_terms.sv
// ----------------------------------------------------------------------------
// ula_terms
// Coefficient times polynomial for the three orders, floored to Q16.16,
// then the exact three-term sum.
// ----------------------------------------------------------------------------
module ula_terms #(
	parameter int SPIN_FRAC_BITS = 15,
	parameter int COEFF_WIDTH    = 32
) (
	input  logic                              clk,
	input  ula_pkg::ula_adv_t                 adv,
	input  logic signed [COEFF_WIDTH-1:0]     k2,
	input  logic signed [COEFF_WIDTH-1:0]     k4,
	input  logic signed [COEFF_WIDTH-1:0]     k6,
	input  logic signed [SPIN_FRAC_BITS+9:0]  p2,
	input  logic signed [SPIN_FRAC_BITS+9:0]  p4,
	input  logic signed [SPIN_FRAC_BITS+9:0]  p6,
	output logic signed [COEFF_WIDTH+11:0]    sum_s6
);
	import ula_pkg::*;

	localparam int F  = SPIN_FRAC_BITS;
	localparam int PW = F + 10;
	localparam int MW = COEFF_WIDTH + PW;
	localparam int TW = MW - F;
	localparam int SW = COEFF_WIDTH + 12;

	logic signed [MW-1:0] m2, m4, m6;
	logic signed [TW-1:0] t2_s5, t4_s5, t6_s5;

	assign m2 = k2 * p2;
	assign m4 = k4 * p4;
	assign m6 = k6 * p6;

	// dropping the low bits of the product floors toward minus infinity
	always_ff @(posedge clk) begin
		if (adv.s5) begin
			t2_s5 <= m2[MW-1:F];
			t4_s5 <= m4[MW-1:F];
			t6_s5 <= m6[MW-1:F];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			sum_s6 <= SW'(t2_s5) + SW'(t4_s5) + SW'(t6_s5);
		end
	end

endmodule

FILE: src/ula_checker.sv
// ----------------------------------------------------------------------------
// ula_checker
// Port-level checks on the anisotropy evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module ula_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [ula_pkg::OUT_WIDTH-1:0] result_value
);
	import ula_pkg::*;

	localparam logic [3:0] PIPE_DEPTH = 4'd7;

	logic [3:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// requests inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else begin
			cnt_q <= cnt_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("result changed while stalled");

	// with the output draining every stage moves, so no back-pressure
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PIPE_DEPTH)
		else $error("more requests in flight than stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 4'd0)
		else $error("result offered with nothing in flight");

endmodule

bind uniaxial_legendre_anisotropy ula_checker u_ula_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value)
);
